// File: rtl/core/alhs_pkg.sv
package alhs_pkg;

  // sample width default and fixed field widths
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int PCT_W           = 7;
  localparam int THR_W           = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int EVENT_W         = 2;

  // calibration range after reset or range command
  localparam int RANGE_LOW_INIT  = 1022;
  localparam int RANGE_HIGH_INIT = 2;
  localparam int PCT_FULL        = 100;

  // threshold reset values
  localparam logic [THR_W-1:0] DARK_THR_INIT   = THR_W'(30);
  localparam logic [THR_W-1:0] BRIGHT_THR_INIT = THR_W'(70);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_THR   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_THR = CFG_IDX_W'(1);

  // switch event codes
  localparam logic [EVENT_W-1:0] EV_NONE = EVENT_W'(0);
  localparam logic [EVENT_W-1:0] EV_ON   = EVENT_W'(1);
  localparam logic [EVENT_W-1:0] EV_OFF  = EVENT_W'(2);

endpackage

// File: rtl/core/autorange_light_hysteresis_switch_top.sv
// sequence: a sample goes from idle through S_SCALE and the divider to S_OUT, an empty
// range skips the division, a range command goes straight to S_OUT; a result held back
// by a stalled receiver waits in S_OUT; items are taken only in idle, paced by the
// 7-step shared compare-subtract divider; the next item is taken while a result still waits
// reset (synchronous, active low): range 1022 / 2 truncated to the sample width, state dark,
// thresholds 30 and 70, no result pending
module autorange_light_hysteresis_switch_top #(
  parameter int SAMPLE_BITS = alhs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [alhs_pkg::PCT_W-1:0]        out_percent,
  output logic                              out_range_changed,
  output logic [alhs_pkg::EVENT_W-1:0]      out_switch_event,
  output logic                              out_is_bright,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [alhs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [alhs_pkg::THR_W-1:0]        cfg_data
);
  import alhs_pkg::*;

  localparam int SW = SAMPLE_BITS;
  localparam int NW = SAMPLE_BITS + PCT_W;
  localparam logic [SW-1:0] LOW_INIT  = SW'(RANGE_LOW_INIT);
  localparam logic [SW-1:0] HIGH_INIT = SW'(RANGE_HIGH_INIT);

  typedef enum logic [1:0] {S_IDLE, S_SCALE, S_DIV, S_OUT} state_t;

  state_t             state_r;
  logic [SW-1:0]      lo_r;
  logic [SW-1:0]      hi_r;
  logic [SW-1:0]      x_r;
  logic               cmd_r;
  logic               changed_r;
  logic [PCT_W-1:0]   pct_r;
  logic               bright_r;
  logic [THR_W-1:0]   dark_thr_r;
  logic [THR_W-1:0]   bright_thr_r;
  logic               out_valid_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic               out_changed_r;
  logic [EVENT_W-1:0] out_event_r;
  logic               out_bright_r;

  logic               in_xfer;
  logic [SW-1:0]      span;
  logic [SW-1:0]      diff;
  logic [NW-1:0]      numer;
  logic               div_start;
  logic               div_done;
  logic [PCT_W-1:0]   div_q;
  logic               bright_nxt;
  logic [EVENT_W-1:0] event_nxt;
  logic               out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // scaling operands from the widened range
  always_comb begin
    span      = hi_r - lo_r;
    diff      = x_r - lo_r;
    numer     = NW'(diff) * NW'(PCT_FULL);
    div_start = (state_r == S_SCALE) && (span != '0);
  end

  alhs_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (numer),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_q)
  );

  // hysteresis comparator, bright test wins
  always_comb begin
    if (pct_r > bright_thr_r) begin
      bright_nxt = 1'b1;
    end else if (pct_r < dark_thr_r) begin
      bright_nxt = 1'b0;
    end else begin
      bright_nxt = bright_r;
    end
    if (cmd_r || (bright_nxt == bright_r)) begin
      event_nxt = EV_NONE;
    end else if (bright_nxt) begin
      event_nxt = EV_OFF;
    end else begin
      event_nxt = EV_ON;
    end
  end

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_thr_r   <= DARK_THR_INIT;
      bright_thr_r <= BRIGHT_THR_INIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DARK_THR:   dark_thr_r   <= cfg_data;
        CFG_BRIGHT_THR: bright_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, range tracking and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lo_r        <= LOW_INIT;
      hi_r        <= HIGH_INIT;
      bright_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            cmd_r <= in_cmd;
            x_r   <= in_sample;
            if (in_cmd) begin
              lo_r      <= LOW_INIT;
              hi_r      <= HIGH_INIT;
              changed_r <= 1'b0;
              pct_r     <= '0;
              state_r   <= S_OUT;
            end else begin
              if (in_sample < lo_r) begin
                lo_r <= in_sample;
              end
              if (in_sample > hi_r) begin
                hi_r <= in_sample;
              end
              changed_r <= (in_sample < lo_r) || (in_sample > hi_r);
              state_r   <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          // empty range gives zero without a division
          if (span == '0) begin
            pct_r   <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pct_r   <= div_q;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_pct_r     <= pct_r;
            out_changed_r <= changed_r;
            out_event_r   <= event_nxt;
            if (!cmd_r) begin
              bright_r     <= bright_nxt;
              out_bright_r <= bright_nxt;
            end else begin
              out_bright_r <= bright_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_percent       = out_pct_r;
  assign out_range_changed = out_changed_r;
  assign out_switch_event  = out_event_r;
  assign out_is_bright     = out_bright_r;

endmodule

// File: rtl/core/alhs_div.sv
module alhs_div #(
  parameter int SAMPLE_BITS = alhs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic [SAMPLE_BITS+alhs_pkg::PCT_W-1:0]    dividend,
  input  logic [SAMPLE_BITS-1:0]                    divisor,
  output logic                                      done,
  output logic [alhs_pkg::PCT_W-1:0]                quotient
);
  import alhs_pkg::*;

  localparam int NW    = SAMPLE_BITS + PCT_W;
  localparam int CNT_W = $clog2(PCT_W);

  logic [NW-1:0]    rem_r;
  logic [NW-1:0]    ds_r;
  logic [PCT_W-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             ge;
  logic [NW-1:0]    rem_sub;

  // shared compare and subtract step
  always_comb begin
    ge      = (rem_r >= ds_r);
    rem_sub = rem_r - ds_r;
  end

  // restoring division, one quotient bit a cycle, msb first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(PCT_W - 1);
        rem_r  <= dividend;
        ds_r   <= {1'b0, divisor, {(PCT_W-1){1'b0}}};
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_sub;
        end
        ds_r <= ds_r >> 1;
        q_r  <= {q_r[PCT_W-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
